// File: design/fba_pkg.sv
// Shared types and constants for the frame bitmap allocator.
// Holds the operation codes, register indexes and the controller/datapath interface structs.
// No dependencies.
`timescale 1ns / 1ps

package fba_pkg;

  localparam int MAX_FRAMES_DEF = 4096;
  localparam int WORD_BITS_DEF  = 32;

  localparam int FRAME_W   = 20;
  localparam int COUNT_W   = 13;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_ADDR_W-1:0] CFG_BASE_FRAME  = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_POOL_FRAMES = 1'b1;

  localparam logic [COUNT_W-1:0] POOL_RESET = 13'd4096;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_MARK    = 2'd1,
    OP_RELEASE = 2'd2
  } op_t;

  typedef struct packed {
    logic clr_step;
    logic accept;
    logic setup;
    logic step;
    logic process;
    logic load_out;
  } fba_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic walk_needed;
    logic proc_valid;
    logic last;
    logic out_full;
  } fba_status_t;

endpackage

// File: design/fba_ctrl.sv
// Sequencing state machine of the frame bitmap allocator.
// Drives the datapath by command struct and reads its status struct; uses fba_pkg.
`timescale 1ns / 1ps

module fba_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 out_ready,
  input  fba_pkg::fba_status_t st,
  output fba_pkg::fba_cmd_t    cmd
);
  import fba_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SETUP,
    S_WALK,
    S_FINISH
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      in_ready <= 1'b0;
    end else begin
      case (state)
        S_CLEAR: begin
          if (st.clr_last) begin
            state    <= S_IDLE;
            in_ready <= 1'b1;
          end
        end
        S_IDLE: begin
          if (in_valid && in_ready) begin
            state    <= S_SETUP;
            in_ready <= 1'b0;
          end
        end
        S_SETUP: begin
          state <= st.walk_needed ? S_WALK : S_FINISH;
        end
        S_WALK: begin
          if (st.proc_valid && st.last) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (!st.out_full || out_ready) begin
            state    <= S_IDLE;
            in_ready <= 1'b1;
          end
        end
        default: begin
          state    <= S_IDLE;
          in_ready <= 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    cmd          = '0;
    cmd.clr_step = (state == S_CLEAR);
    cmd.accept   = (state == S_IDLE) && in_valid && in_ready;
    cmd.setup    = (state == S_SETUP);
    cmd.step     = (state == S_WALK) && !(st.proc_valid && st.last);
    cmd.process  = (state == S_WALK) && st.proc_valid;
    cmd.load_out = (state == S_FINISH) && (!st.out_full || out_ready);
  end

endmodule

// File: design/fba_dpath.sv
// Datapath of the frame bitmap allocator: registers, bitmap memory and word walker.
// Commanded by fba_ctrl through fba_pkg structs.
`timescale 1ns / 1ps

module fba_dpath #(
  parameter int MAX_FRAMES = fba_pkg::MAX_FRAMES_DEF,
  parameter int WORD_BITS  = fba_pkg::WORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [fba_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [fba_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [1:0]                      in_op,
  input  logic [fba_pkg::FRAME_W-1:0]     in_frame_number,
  input  logic [fba_pkg::COUNT_W-1:0]     in_frame_count,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [fba_pkg::FRAME_W-1:0]     out_frame,
  output logic                            out_ok,
  input  fba_pkg::fba_cmd_t               cmd,
  output fba_pkg::fba_status_t            st
);
  import fba_pkg::*;

  localparam int MAP_WORDS = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int CNT_W     = $clog2(MAX_FRAMES + 1);
  localparam int CW        = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
  localparam int BW        = CW + 1;
  localparam int XW        = (FRAME_W > CW) ? FRAME_W : CW;
  localparam int SW        = (FRAME_W > BW) ? FRAME_W : BW;
  localparam int PB        = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;

  logic [WORD_BITS-1:0] mem [MAP_WORDS];
  logic [WORD_BITS-1:0] rd_data;

  logic [FRAME_W-1:0] base_frame;
  logic [COUNT_W-1:0] pool_frames;

  op_t                op_q;
  logic [FRAME_W-1:0] fnum_q;
  logic [COUNT_W-1:0] cnt_q;

  logic [CW-1:0] lo;
  logic [CW-1:0] hi;

  logic [AW-1:0] rd_addr;
  logic [BW-1:0] rd_wbase;
  logic [AW-1:0] proc_addr;
  logic [BW-1:0] proc_wbase;
  logic          proc_valid;

  logic               res_ok;
  logic [FRAME_W-1:0] res_frame;

  // Setup computations.
  logic [CW-1:0]  pool_eff;
  logic [FRAME_W-1:0] rel;
  logic           in_pool;
  logic [CW:0]    run_end;
  logic [CW-1:0]  mark_hi;
  logic [CW-1:0]  setup_lo;
  logic [CW-1:0]  setup_hi;
  logic           setup_ok;
  logic           walk_needed;

  always_comb begin
    pool_eff = (CW'(pool_frames) >= CW'(MAX_FRAMES)) ? CW'(MAX_FRAMES) : CW'(pool_frames);
    rel      = fnum_q - base_frame;
    in_pool  = (fnum_q >= base_frame) && (XW'(rel) < XW'(pool_eff));
    run_end  = {1'b0, rel[CW-1:0]} + (CW+1)'(cnt_q);
    mark_hi  = (run_end > {1'b0, pool_eff}) ? pool_eff : run_end[CW-1:0];
    setup_lo = rel[CW-1:0];
    setup_hi = '0;
    setup_ok = 1'b0;
    walk_needed = 1'b0;
    case (op_q)
      OP_ALLOC: begin
        setup_lo    = '0;
        setup_hi    = pool_eff;
        walk_needed = (pool_eff != '0);
      end
      OP_MARK: begin
        setup_hi    = mark_hi;
        setup_ok    = in_pool;
        walk_needed = in_pool && (mark_hi > rel[CW-1:0]);
      end
      OP_RELEASE: begin
        setup_hi    = rel[CW-1:0] + CW'(1);
        setup_ok    = in_pool;
        walk_needed = in_pool;
      end
      default: begin
        setup_lo = '0;
      end
    endcase
  end

  // Word processing; index j of a word maps to memory bit WORD_BITS-1-j.
  logic [WORD_BITS-1:0] word_idx;
  logic [WORD_BITS-1:0] range_mask;
  logic [WORD_BITS-1:0] cand;
  logic [WORD_BITS-1:0] first_hot;
  logic [WORD_BITS-1:0] new_idx;
  logic [WORD_BITS-1:0] wr_data;
  logic [PB-1:0]        pos;
  logic                 found;
  logic [BW-1:0]        found_idx;
  logic [SW-1:0]        res_sum;
  logic [BW:0]          next_base;
  logic                 last;

  always_comb begin
    for (int j = 0; j < WORD_BITS; j++) begin
      word_idx[j]   = rd_data[WORD_BITS-1-j];
      range_mask[j] = ((proc_wbase + BW'(j)) >= BW'(lo)) && ((proc_wbase + BW'(j)) < BW'(hi));
    end
    cand      = word_idx & range_mask;
    first_hot = cand & (~cand + WORD_BITS'(1));
    found     = (cand != '0);
    pos       = '0;
    for (int j = 0; j < WORD_BITS; j++) begin
      if (first_hot[j]) begin
        pos = pos | PB'(j);
      end
    end
    case (op_q)
      OP_ALLOC:   new_idx = word_idx & ~first_hot;
      OP_MARK:    new_idx = word_idx & ~range_mask;
      OP_RELEASE: new_idx = word_idx | range_mask;
      default:    new_idx = word_idx;
    endcase
    for (int j = 0; j < WORD_BITS; j++) begin
      wr_data[WORD_BITS-1-j] = new_idx[j];
    end
    found_idx = proc_wbase + BW'(pos);
    res_sum   = SW'(base_frame) + SW'(found_idx);
    next_base = {1'b0, proc_wbase} + (BW+1)'(WORD_BITS);
    last      = ((op_q == OP_ALLOC) && found) || (next_base >= (BW+1)'(hi)) ||
                (proc_addr == AW'(MAP_WORDS - 1));
  end

  always_comb begin
    st             = '0;
    st.clr_last    = (rd_addr == AW'(MAP_WORDS - 1));
    st.walk_needed = walk_needed;
    st.proc_valid  = proc_valid;
    st.last        = last;
    st.out_full    = out_valid;
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      mem[rd_addr] <= {WORD_BITS{1'b1}};
    end else if (cmd.process) begin
      mem[proc_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_frame  <= '0;
      pool_frames <= POOL_RESET;
      rd_addr     <= '0;
      rd_wbase    <= '0;
      proc_valid  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_BASE_FRAME:  base_frame  <= cfg_data;
          CFG_POOL_FRAMES: pool_frames <= cfg_data[COUNT_W-1:0];
          default: ;
        endcase
      end
      if (cmd.clr_step) begin
        rd_addr <= rd_addr + AW'(1);
      end else if (cmd.setup) begin
        rd_addr  <= '0;
        rd_wbase <= '0;
      end else if (cmd.step) begin
        rd_addr  <= rd_addr + AW'(1);
        rd_wbase <= rd_wbase + BW'(WORD_BITS);
      end
      proc_valid <= cmd.step;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q   <= op_t'(in_op);
      fnum_q <= in_frame_number;
      cnt_q  <= in_frame_count;
    end
    if (cmd.setup) begin
      lo        <= setup_lo;
      hi        <= setup_hi;
      res_ok    <= setup_ok;
      res_frame <= '0;
    end
    if (cmd.step) begin
      proc_addr  <= rd_addr;
      proc_wbase <= rd_wbase;
    end
    if (cmd.process && (op_q == OP_ALLOC) && found) begin
      res_ok    <= 1'b1;
      res_frame <= res_sum[FRAME_W-1:0];
    end
    if (cmd.load_out) begin
      out_frame <= res_frame;
      out_ok    <= res_ok;
    end
  end

endmodule

// File: design/frame_bitmap_allocator_unit.sv
// Top level of the frame bitmap allocator: stream ports, configuration port.
// Instantiates fba_ctrl and fba_dpath; uses fba_pkg.
//
// Usage: one bit per frame marks it free (all frames free after reset).
// Input items arrive on s_tvalid/s_tready with the operation in s_tuser and
// the frame number and count in s_tdata. Every item gives exactly one result
// item on m_tvalid/m_tready: the allocated frame in m_tdata and ok in m_tuser.
// Registers base_frame (index 0) and pool_frames (index 1) are written through
// cfg_we/cfg_addr/cfg_data, by the user only while the block is idle; the block does not enforce it.
// An item walks the bitmap one word per cycle from word zero until the
// frames it covers are done, the last word is reached or a free frame is found;
// the bitmap memory has one write port and one registered read port.
// One item is worked on at a time; the next is taken once the result has
// moved into the output register.
// After reset a clearing pass writes all ones to the MAP_WORDS words (128 by
// default), during which s_tready stays low. A stalled receiver holds the
// result in the output register and stops intake at the next result.
`timescale 1ns / 1ps

module frame_bitmap_allocator_unit #(
  parameter int MAX_FRAMES = fba_pkg::MAX_FRAMES_DEF,
  parameter int WORD_BITS  = fba_pkg::WORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [39:0]                    s_tdata,   // frame_number, frame_count
  input  logic [1:0]                     s_tuser,   // op
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [23:0]                    m_tdata,   // result_frame
  output logic                           m_tuser,   // ok
  input  logic                           cfg_we,
  input  logic [fba_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [fba_pkg::CFG_DATA_W-1:0] cfg_data
);
  import fba_pkg::*;

  fba_cmd_t           cmd;
  fba_status_t        st;
  logic [FRAME_W-1:0] out_frame;

  fba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_ready (m_tready),
    .st        (st),
    .cmd       (cmd)
  );

  fba_dpath #(
    .MAX_FRAMES (MAX_FRAMES),
    .WORD_BITS  (WORD_BITS)
  ) u_dpath (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_addr        (cfg_addr),
    .cfg_data        (cfg_data),
    .in_op           (s_tuser),
    .in_frame_number (s_tdata[19:0]),
    .in_frame_count  (s_tdata[32:20]),
    .out_ready       (m_tready),
    .out_valid       (m_tvalid),
    .out_frame       (out_frame),
    .out_ok          (m_tuser),
    .cmd             (cmd),
    .st              (st)
  );

  assign m_tdata = {4'b0000, out_frame};

endmodule

// File: test/frame_bitmap_allocator_unit_tb.sv
// Self-checking testbench for frame_bitmap_allocator_unit: directed and random allocate,
// mark-range and release items, with random idling on both streams and a long output stall.
// Depends on fba_pkg and the design sources; the checker keeps its own copy of the free map.
`timescale 1ns / 1ps

module frame_bitmap_allocator_unit_tb;
  import fba_pkg::*;

  localparam int MAP_FRAMES = MAX_FRAMES_DEF;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int HOLD_AT = 60;
  localparam int HOLD_CYCLES = 500;
  localparam int DRAIN_CYCLES = 150;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic ok;
  } frame_result_t;

  class frame_map_scoreboard;
    bit free_bits [MAP_FRAMES];
    logic [FRAME_W-1:0] base_frame;
    logic [COUNT_W-1:0] pool_frames;
    frame_result_t due_q [$];
    int errors;

    function new();
      foreach (free_bits[i]) free_bits[i] = 1'b1;
      base_frame = '0;
      pool_frames = POOL_RESET;
      errors = 0;
    endfunction

    function void set_register(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
      if (addr == CFG_BASE_FRAME) base_frame = data[FRAME_W-1:0];
      else if (addr == CFG_POOL_FRAMES) pool_frames = data[COUNT_W-1:0];
    endfunction

    function int pending();
      return due_q.size();
    endfunction

    function void note_request(logic [1:0] op_code, logic [FRAME_W-1:0] fnum,
                               logic [COUNT_W-1:0] cnt);
      frame_result_t r;
      int span, idx, start, stop;
      bit in_pool;
      r = '0;
      span = (int'(pool_frames) < MAP_FRAMES) ? int'(pool_frames) : MAP_FRAMES;
      in_pool = (fnum >= base_frame) && (int'(fnum) - int'(base_frame) < span);
      start = int'(fnum) - int'(base_frame);
      case (op_code)
        OP_ALLOC: begin
          for (idx = 0; idx < span && !r.ok; idx++) begin
            if (free_bits[idx]) begin
              free_bits[idx] = 1'b0;
              r.frame = base_frame + FRAME_W'(idx);
              r.ok = 1'b1;
            end
          end
        end
        OP_MARK: begin
          if (in_pool) begin
            stop = start + int'(cnt);
            if (stop > span) stop = span;
            for (idx = start; idx < stop; idx++) free_bits[idx] = 1'b0;
            r.ok = 1'b1;
          end
        end
        OP_RELEASE: begin
          if (in_pool) begin
            free_bits[start] = 1'b1;
            r.ok = 1'b1;
          end
        end
        default: ;
      endcase
      due_q.push_back(r);
    endfunction

    function void check_result(logic [23:0] data, logic ok_bit);
      frame_result_t r;
      if (due_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result frame=%h ok=%b", $time, data, ok_bit);
        return;
      end
      r = due_q.pop_front();
      if (data !== {4'd0, r.frame}) begin
        errors++;
        $display("%0t: result_frame expected %h actual %h", $time, {4'd0, r.frame}, data);
      end
      if (ok_bit !== r.ok) begin
        errors++;
        $display("%0t: ok expected %b actual %b", $time, r.ok, ok_bit);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [39:0] s_tdata;  // frame_number, frame_count
  logic [1:0] s_tuser;   // op
  logic m_tvalid;
  logic m_tready;
  logic [23:0] m_tdata;  // result_frame
  logic m_tuser;         // ok
  logic cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_data;

  frame_map_scoreboard sb = new();
  int tx_gap_max = 18;
  int stall_cycles = 0;

  frame_bitmap_allocator_unit uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
      if (s_tvalid && s_tready) sb.note_request(s_tuser, s_tdata[19:0], s_tdata[32:20]);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : result_sink
    int gap;
    int taken;
    int gap_max;
    gap_max = 18;
    taken = 0;
    m_tready = 1'b0;
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      if (taken == HOLD_AT) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (taken % 50 == 0) gap_max = ($urandom_range(0, 3) == 0) ? 0 : 18;
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      @(negedge clk);
      taken++;
    end
  end

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_data <= data;
    sb.set_register(addr, data);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_item(input logic [1:0] op_code, input logic [FRAME_W-1:0] fnum,
                           input logic [COUNT_W-1:0] cnt);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op_code;
    s_tdata <= {7'd0, cnt, fnum};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic finish_phase();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin : stimulus
    int phase;
    int n;
    int items;
    int span;
    int pick;
    logic [CFG_DATA_W-1:0] base_val;
    logic [CFG_DATA_W-1:0] pool_val;
    logic [1:0] op_code;
    logic [FRAME_W-1:0] fnum;
    logic [COUNT_W-1:0] cnt;

    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_data = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Small pool: first fit, double release, clipping, exhaustion, out-of-pool frames.
    write_reg(CFG_BASE_FRAME, 20'h00100);
    write_reg(CFG_POOL_FRAMES, 20'd8);
    send_item(OP_ALLOC, 20'h0, 13'd0);
    send_item(OP_ALLOC, 20'hFFFFF, 13'h1FFF);
    send_item(OP_ALLOC, 20'h0, 13'd0);
    send_item(OP_RELEASE, 20'h00101, 13'd0);
    send_item(OP_RELEASE, 20'h00101, 13'd0);
    send_item(OP_ALLOC, 20'h0, 13'd0);
    send_item(OP_RELEASE, 20'h000FF, 13'd0);
    send_item(OP_RELEASE, 20'h00108, 13'd0);
    send_item(OP_MARK, 20'h00105, 13'd0);
    send_item(OP_MARK, 20'h00104, 13'h1FFF);
    send_item(OP_ALLOC, 20'h0, 13'd0);
    send_item(OP_ALLOC, 20'h0, 13'd0);
    send_item(OP_MARK, 20'h000FF, 13'd2);
    send_item(OP_MARK, 20'h00108, 13'd1);
    send_item(OP_UNUSED, 20'hFFFFF, 13'h1FFF);
    send_item(OP_RELEASE, 20'h00107, 13'd0);
    send_item(OP_ALLOC, 20'h0, 13'd0);
    finish_phase();

    // Base at the top of the frame space so results wrap; pool above storage size.
    write_reg(CFG_BASE_FRAME, 20'hFFFFE);
    write_reg(CFG_POOL_FRAMES, 20'h01FFF);
    send_item(OP_ALLOC, 20'h0, 13'd0);
    send_item(OP_ALLOC, 20'h0, 13'd0);
    send_item(OP_RELEASE, 20'h00005, 13'd0);
    send_item(OP_RELEASE, 20'hFFFFE, 13'd0);
    send_item(OP_MARK, 20'hFFFFF, 13'd5);
    send_item(OP_ALLOC, 20'h0, 13'd0);
    send_item(OP_ALLOC, 20'h0, 13'd0);
    finish_phase();

    write_reg(CFG_POOL_FRAMES, 20'd0);
    send_item(OP_ALLOC, 20'h0, 13'd0);
    send_item(OP_RELEASE, 20'hFFFFE, 13'd0);
    finish_phase();

    for (phase = 0; phase < 8; phase++) begin
      items = 100;
      case (phase)
        0: begin base_val = 20'h00000; pool_val = 20'd4096; items = 130; end
        1: begin base_val = 20'h12345; pool_val = 20'h02040; items = 110; end
        2: begin base_val = 20'hFFFFF; pool_val = 20'd4096; end
        3: begin base_val = CFG_DATA_W'($urandom_range(0, 20'hFFFFF)); pool_val = 20'd200; end
        4: begin base_val = 20'h00000; pool_val = 20'd33; end
        5: begin
          base_val = CFG_DATA_W'($urandom_range(0, 20'hFFFFF));
          pool_val = 20'h01FFF;
        end
        6: begin base_val = 20'h00001; pool_val = 20'd1; items = 60; end
        default: begin
          base_val = CFG_DATA_W'($urandom_range(0, 20'hFFFFF));
          pool_val = CFG_DATA_W'($urandom_range(0, 4096));
        end
      endcase
      write_reg(CFG_BASE_FRAME, base_val);
      write_reg(CFG_POOL_FRAMES, pool_val);
      tx_gap_max = (phase % 3 == 1) ? 0 : 18;
      span = (int'(pool_val[COUNT_W-1:0]) < MAP_FRAMES) ? int'(pool_val[COUNT_W-1:0])
                                                         : MAP_FRAMES;
      for (n = 0; n < items; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 45) op_code = OP_ALLOC;
        else if (pick < 72) op_code = OP_RELEASE;
        else if (pick < 94) op_code = OP_MARK;
        else op_code = OP_UNUSED;
        pick = $urandom_range(0, 9);
        if (pick < 2) fnum = FRAME_W'($urandom_range(0, 20'hFFFFF));
        else if (pick == 2) fnum = base_val[FRAME_W-1:0] - FRAME_W'($urandom_range(1, 3));
        else fnum = base_val[FRAME_W-1:0] + FRAME_W'($urandom_range(0, span + 1));
        pick = $urandom_range(0, 19);
        if (pick == 0) cnt = COUNT_W'($urandom_range(0, 13'h1FFF));
        else if (pick == 1) cnt = 13'd0;
        else cnt = COUNT_W'($urandom_range(1, 24));
        send_item(op_code, fnum, cnt);
      end
      finish_phase();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
